@@ hdl/dcbm_pkg.sv @@
package dcbm_pkg;

	localparam int WINDOW_LEN_DEF = 7;
	localparam int TEMP_W         = 11;
	localparam int HUM_W          = 10;
	// compare key: temperature with sign bit flipped, humidity zero-extended
	localparam int KEY_W          = TEMP_W;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_value;
		logic                     temp_valid;
		logic        [HUM_W-1:0]  hum_value;
		logic                     hum_valid;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_median;
		logic        [HUM_W-1:0]  hum_median;
	} median_t;

endpackage

@@ hdl/dual_channel_block_median.sv @@
// channel   direction  handshake                      payload
// sample    in         sample_valid / sample_ready    dcbm_pkg::sample_t
// median    out        median_valid / median_ready    dcbm_pkg::median_t
//
// a sample beat that is not the last of a window is stored and leaves the block idle
// the last beat of a window starts the median search: for each channel every
// candidate is loaded and then compared with every slot through the one
// shared key comparator, first for temperature and then for humidity
// reset clears both sample rings to zero, the slot count and the median beat
// a pending median beat holds only the last sample of the next window
module dual_channel_block_median #(
	parameter int WINDOW_LEN = dcbm_pkg::WINDOW_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  dcbm_pkg::sample_t sample,
	output logic              median_valid,
	input  logic              median_ready,
	output dcbm_pkg::median_t median
);
	import dcbm_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_LEN);
	localparam int CNT_W = $clog2(WINDOW_LEN + 1);
	localparam logic [CNT_W-1:0] MID  = CNT_W'((WINDOW_LEN - 1) / 2);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_LEN - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CMP
	} state_t;

	state_t                   state_q;
	// sample rings, slot order does not matter for the median
	logic signed [TEMP_W-1:0] temp_ring_q [WINDOW_LEN];
	logic        [HUM_W-1:0]  hum_ring_q  [WINDOW_LEN];
	logic        [IDX_W-1:0]  slot_q;
	logic        [IDX_W-1:0]  step_q;     // compare step within one candidate
	logic        [IDX_W-1:0]  cand_idx_q; // candidates tried on this channel
	logic                     chan_q;     // 0 = temperature, 1 = humidity
	logic        [KEY_W-1:0]  cand_q;
	logic        [CNT_W-1:0]  lt_q;
	logic        [CNT_W-1:0]  le_q;
	logic signed [TEMP_W-1:0] temp_med_q;
	median_t                  median_q;
	logic                     median_valid_q;

	logic                     accept;
	logic                     last_slot;
	logic signed [TEMP_W-1:0] temp_in;
	logic        [HUM_W-1:0]  hum_in;
	logic        [KEY_W-1:0]  head_key;
	logic                     key_lt;
	logic                     key_eq;
	logic        [CNT_W-1:0]  lt_n;
	logic        [CNT_W-1:0]  le_n;
	logic                     found;

	assign last_slot    = (slot_q == LAST);
	// the last beat of a window needs the median register free
	assign sample_ready = (state_q == ST_IDLE) && !(last_slot && median_valid_q);
	assign accept       = sample_valid && sample_ready;

	// invalid temperature blanks both slots, invalid humidity only its own
	assign temp_in = sample.temp_valid ? sample.temp_value : '0;
	assign hum_in  = (sample.temp_valid && sample.hum_valid) ? sample.hum_value : '0;

	// shared comparator on an unsigned key for both channels
	assign head_key = chan_q ? {1'b0, hum_ring_q[0]}
	                         : {~temp_ring_q[0][TEMP_W-1], temp_ring_q[0][TEMP_W-2:0]};
	assign key_lt   = head_key < cand_q;
	assign key_eq   = head_key == cand_q;
	assign lt_n     = lt_q + CNT_W'(key_lt);
	assign le_n     = le_q + CNT_W'(key_lt || key_eq);
	// candidate ranks at the middle when fewer than MID+1 lie below it
	// and more than MID lie at or below it
	assign found    = (lt_n <= MID) && (le_n > MID);

	assign median_valid = median_valid_q;
	assign median       = median_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			slot_q         <= '0;
			step_q         <= '0;
			cand_idx_q     <= '0;
			chan_q         <= 1'b0;
			cand_q         <= '0;
			lt_q           <= '0;
			le_q           <= '0;
			temp_med_q     <= '0;
			median_q       <= '0;
			median_valid_q <= 1'b0;
			for (int k = 0; k < WINDOW_LEN; k++) begin
				temp_ring_q[k] <= '0;
				hum_ring_q[k]  <= '0;
			end
		end else begin
			if (median_valid_q && median_ready) begin
				median_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// shift the new beat in at the tail
						for (int k = 0; k < WINDOW_LEN - 1; k++) begin
							temp_ring_q[k] <= temp_ring_q[k+1];
							hum_ring_q[k]  <= hum_ring_q[k+1];
						end
						temp_ring_q[WINDOW_LEN-1] <= temp_in;
						hum_ring_q[WINDOW_LEN-1]  <= hum_in;
						if (last_slot) begin
							slot_q     <= '0;
							chan_q     <= 1'b0;
							cand_idx_q <= '0;
							state_q    <= ST_LOAD;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
					end
				end
				ST_LOAD: begin
					// take the head as candidate, one extra rotation moves
					// the next candidate to the head one pass later
					cand_q <= head_key;
					lt_q   <= '0;
					le_q   <= '0;
					step_q <= '0;
					for (int k = 0; k < WINDOW_LEN; k++) begin
						temp_ring_q[k] <= temp_ring_q[(k + 1) % WINDOW_LEN];
						hum_ring_q[k]  <= hum_ring_q[(k + 1) % WINDOW_LEN];
					end
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					lt_q   <= lt_n;
					le_q   <= le_n;
					step_q <= step_q + 1'b1;
					if ((step_q == LAST) && found && !chan_q) begin
						for (int k = 0; k < WINDOW_LEN; k++) begin
							temp_ring_q[k] <= temp_ring_q[(k + 1) % WINDOW_LEN];
							hum_ring_q[k]  <= hum_ring_q[(k + 1) % WINDOW_LEN];
						end
						temp_med_q <= {~cand_q[KEY_W-1], cand_q[KEY_W-2:0]};
						chan_q     <= 1'b1;
						cand_idx_q <= '0;
						state_q    <= ST_LOAD;
					end else if ((step_q == LAST) && (found || (cand_idx_q == LAST))) begin
						// humidity done: publish and start a fresh window
						median_q.temp_median <= temp_med_q;
						median_q.hum_median  <= cand_q[HUM_W-1:0];
						median_valid_q       <= 1'b1;
						for (int k = 0; k < WINDOW_LEN; k++) begin
							temp_ring_q[k] <= '0;
							hum_ring_q[k]  <= '0;
						end
						state_q <= ST_IDLE;
					end else begin
						for (int k = 0; k < WINDOW_LEN; k++) begin
							temp_ring_q[k] <= temp_ring_q[(k + 1) % WINDOW_LEN];
							hum_ring_q[k]  <= hum_ring_q[(k + 1) % WINDOW_LEN];
						end
						if (step_q == LAST) begin
							cand_idx_q <= cand_idx_q + 1'b1;
							state_q    <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/dcbm_check.sv @@
module dcbm_check (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input logic              median_valid,
	input logic              median_ready,
	input dcbm_pkg::median_t median
);
	import dcbm_pkg::*;

	// a stalled median beat holds its value
	a_median_hold: assert property (@(posedge clk) disable iff (!arst_n)
		median_valid && !median_ready |=> median_valid && $stable(median))
		else $error("median beat changed while stalled");

	// no median beat rises straight after an accepted sample beat; the search lies between them
	a_no_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(median_valid) |-> $past(!(sample_valid && sample_ready)))
		else $error("median beat right after a sample beat");

	// input is closed while the search runs
	a_busy_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(median_valid) |-> $past(!sample_ready))
		else $error("sample channel open during median search");

	// a new window opens as soon as the median is out
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(median_valid) |-> sample_ready)
		else $error("sample channel not reopened with median beat");

endmodule

bind dual_channel_block_median dcbm_check u_dcbm_check (.*);

@@ tb/dual_channel_block_median_test.sv @@
module dual_channel_block_median_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dcbm_pkg::*;

	localparam int WIN         = WINDOW_LEN_DEF;
	localparam int MID_RANK    = (WIN - 1) / 2;
	// slowest case: long sender gaps on every beat, a full search and a sparse
	// receiver on every window, plus the drain pauses; this is several times that
	localparam int CYCLE_LIMIT = 400000;
	// tail wait with a margin over the longest median search
	localparam int TAIL_CYCLES = 4 * WIN * (WIN + 1);

	// how the receiver side throttles median beats
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_PERIODIC
	} ready_mode_t;

	// how random sample values are drawn within one window
	typedef enum logic [1:0] {
		VALS_FULL_BITS,
		VALS_IN_RANGE,
		VALS_CLUSTER
	} value_style_t;

	// how often the valid flags of a reading drop
	typedef enum logic [1:0] {
		FLAGS_ALL_OK,
		FLAGS_FEW_BAD,
		FLAGS_HALF_BAD
	} flag_style_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_ready;
	sample_t sample       = '0;
	logic    median_valid;
	logic    median_ready = 1'b0;
	median_t median;

	dual_channel_block_median dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.median_valid(median_valid),
		.median_ready(median_ready),
		.median      (median)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the two sample rings and the fill position
	logic signed [TEMP_W-1:0] temp_ring [WIN];
	logic        [HUM_W-1:0]  hum_ring  [WIN];
	int                       fill_slot;

	// medians owed by the block, oldest first
	median_t pending_medians [$];

	int          mismatches  = 0;
	int unsigned cycle_count = 0;
	int          burst_left  = 0;

	ready_mode_t ready_mode = READY_ALWAYS;
	int          ready_hold = 0;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles, %0d medians still owed",
				$time, CYCLE_LIMIT, pending_medians.size());
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: switches between throttling modes at random intervals,
	// so full-rate stretches alternate with heavy back-pressure
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_hold = $urandom_range(20, 300);
		end else begin
			ready_hold--;
		end
		case (ready_mode)
			READY_ALWAYS:   median_ready <= 1'b1;
			READY_COIN:     median_ready <= 1'($urandom_range(0, 1));
			READY_SPARSE:   median_ready <= ($urandom_range(0, 7) == 0);
			READY_PERIODIC: median_ready <= cycle_count[2];
		endcase
	end

	// rank selection: the median is the value with at most MID_RANK entries
	// strictly below it and more than MID_RANK at or below it
	function automatic int window_median(input bit of_hum);
		int key [WIN];
		int below;
		int not_above;
		int pick;
		for (int i = 0; i < WIN; i++)
			key[i] = of_hum ? int'(hum_ring[i]) : int'(temp_ring[i]);
		pick = key[0];
		for (int i = 0; i < WIN; i++) begin
			below     = 0;
			not_above = 0;
			for (int j = 0; j < WIN; j++) begin
				if (key[j] < key[i])
					below++;
				if (key[j] <= key[i])
					not_above++;
			end
			if (below <= MID_RANK && MID_RANK < not_above)
				pick = key[i];
		end
		return pick;
	endfunction

	function automatic void clear_rings();
		for (int i = 0; i < WIN; i++) begin
			temp_ring[i] = '0;
			hum_ring[i]  = '0;
		end
		fill_slot = 0;
	endfunction

	// update the shadow rings with one accepted sample beat and queue the
	// median when the window closes
	function automatic void record_sample(input sample_t s);
		median_t m;
		int      t_mid;
		int      h_mid;
		// a failed temperature read leaves both slots at zero, whatever the
		// humidity flag says; a failed humidity read only skips its own slot
		if (s.temp_valid) begin
			temp_ring[fill_slot] = s.temp_value;
			if (s.hum_valid)
				hum_ring[fill_slot] = s.hum_value;
		end
		fill_slot++;
		if (fill_slot == WIN) begin
			t_mid         = window_median(1'b0);
			h_mid         = window_median(1'b1);
			m.temp_median = t_mid[TEMP_W-1:0];
			m.hum_median  = h_mid[HUM_W-1:0];
			pending_medians.push_back(m);
			clear_rings();
		end
	endfunction

	// median channel check, field by field against the oldest owed median
	always @(posedge clk) begin
		median_t want;
		if (arst_n && median_valid && median_ready) begin
			if (pending_medians.size() == 0) begin
				$display("%0t: median beat with none owed: temp %0d hum %0d",
					$time, median.temp_median, median.hum_median);
				mismatches++;
			end else begin
				want = pending_medians.pop_front();
				if (median.temp_median !== want.temp_median) begin
					$display("%0t: temp_median expected %0d actual %0d",
						$time, want.temp_median, median.temp_median);
					mismatches++;
				end
				if (median.hum_median !== want.hum_median) begin
					$display("%0t: hum_median expected %0d actual %0d",
						$time, want.hum_median, median.hum_median);
					mismatches++;
				end
			end
		end
	end

	// one sample beat; the sender runs in bursts with random gaps in between,
	// and valid stays high across back-to-back beats of a burst
	task automatic send_sample(input sample_t s);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do
			@(posedge clk);
		while (!sample_ready);
		record_sample(s);
		burst_left--;
	endtask

	// hold the sender off until every owed median has come back
	task automatic wait_drained();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_medians.size() != 0);
	endtask

	function automatic sample_t reading(input int t, input bit t_ok, input int h,
		input bit h_ok);
		sample_t s;
		s.temp_value = t[TEMP_W-1:0];
		s.temp_valid = t_ok;
		s.hum_value  = h[HUM_W-1:0];
		s.hum_valid  = h_ok;
		return s;
	endfunction

	function automatic sample_t random_reading(input value_style_t vs,
		input flag_style_t fs);
		logic [31:0] r;
		int          t;
		int          h;
		r = $urandom;
		case (vs)
			VALS_FULL_BITS: begin
				t = int'(r[10:0]);
				h = int'(r[20:11]);
			end
			VALS_IN_RANGE: begin
				t = int'($urandom_range(0, 1200)) - 400;
				h = int'($urandom_range(0, 1000));
			end
			default: begin
				// narrow spread so windows are full of ties
				t = int'($urandom_range(0, 6)) - 3;
				h = int'($urandom_range(0, 3));
			end
		endcase
		case (fs)
			FLAGS_ALL_OK:  return reading(t, 1'b1, h, 1'b1);
			FLAGS_FEW_BAD: return reading(t, $urandom_range(0, 7) != 0, h,
				$urandom_range(0, 7) != 0);
			default:       return reading(t, 1'($urandom_range(0, 1)), h,
				1'($urandom_range(0, 1)));
		endcase
	endfunction

	// field extremes, both failure cases, ties, and an all-failed window
	task automatic check_directed_extremes();
		// all good: min and max codes of both fields in one window
		send_sample(reading(-1024, 1'b1,    0, 1'b1));
		send_sample(reading( 1023, 1'b1, 1023, 1'b1));
		send_sample(reading( -400, 1'b1, 1000, 1'b1));
		send_sample(reading(  800, 1'b1,  512, 1'b1));
		send_sample(reading(    0, 1'b1,    1, 1'b1));
		send_sample(reading(   -1, 1'b1,  511, 1'b1));
		send_sample(reading(    1, 1'b1,    0, 1'b1));
		// failed reads mixed in, large values on the dropped beats, repeats
		send_sample(reading(  800, 1'b1, 1000, 1'b1));
		send_sample(reading( 1023, 1'b0, 1023, 1'b1));
		send_sample(reading( -400, 1'b1,  999, 1'b0));
		send_sample(reading(  800, 1'b1, 1000, 1'b1));
		send_sample(reading(-1024, 1'b0,    5, 1'b0));
		send_sample(reading(  800, 1'b1, 1023, 1'b1));
		send_sample(reading(    5, 1'b1,  700, 1'b1));
		// every temperature failed: the window stays all zero
		send_sample(reading( 1023, 1'b0, 1023, 1'b1));
		send_sample(reading(-1024, 1'b0, 1000, 1'b1));
		send_sample(reading(  -1, 1'b0,  511, 1'b0));
		send_sample(reading( 1023, 1'b0, 1023, 1'b1));
		send_sample(reading(  800, 1'b0,  512, 1'b1));
		send_sample(reading(-1024, 1'b0, 1023, 1'b0));
		send_sample(reading( 1023, 1'b0, 1023, 1'b1));
	endtask

	// whole windows with a value style and a flag style drawn per window
	task automatic check_random_windows(input int windows);
		value_style_t vs;
		flag_style_t  fs;
		for (int w = 0; w < windows; w++) begin
			vs = value_style_t'($urandom_range(0, 2));
			fs = flag_style_t'($urandom_range(0, 2));
			for (int k = 0; k < WIN; k++)
				send_sample(random_reading(vs, fs));
		end
	endtask

	// sender stops mid-window now and then until all medians are back
	task automatic check_with_drain_pauses(input int beats);
		for (int n = 0; n < beats; n++) begin
			if (n == 10 || $urandom_range(0, 29) == 0)
				wait_drained();
			send_sample(random_reading(value_style_t'($urandom_range(0, 2)),
				flag_style_t'($urandom_range(0, 2))));
		end
	endtask

	initial begin
		clear_rings();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_directed_extremes();
		check_random_windows(186);
		check_with_drain_pauses(36 * WIN);

		// let the last medians out, then give the block time to show strays
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_medians.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
